// ===== rtl/ssms_pkg.sv =====
// Shared types and constants for the sorted sparse matrix store.
package ssms_pkg;

  localparam int unsigned REG_W       = 11;
  localparam int unsigned IDX_IN_W    = 10;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [REG_W-1:0] DIM_RESET = 11'd1024;

  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_LOOK_RD,
    ST_LOOK_CMP,
    ST_DN_MOVE,
    ST_UP_MOVE,
    ST_UP_INS,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/ssms_mem.sv =====
// Record memory: one write port, one read port with registered read data.
module ssms_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 52
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/sorted_sparse_matrix_store_unit.sv =====
// Top level of the sorted sparse matrix store: sequencer, registers and record memory.
//
// Usage: items arrive on the s_axis channel, one read or write of a matrix
// element per beat; each item gives exactly one result beat on m_axis with
// the stored (read) or previous (write) value and a status code. row_count
// and column_count are written through the cfg port; write them only while
// the block is idle, the block itself does not enforce this. Records live in
// one memory sorted by (row, column); the key compare drives a binary search
// over n records, then a read and a compare look at the found slot. An
// update writes during the look, an insert moves each record above the slot
// up one place and then writes the new record, a removal moves each record
// above the removed one down one place. Out-of-range items go straight from
// idle to the final step; the worst case is set by the single memory write
// port moving one record per cycle. s_axis_tready is high only in the idle
// state. The result goes to an output register, so a new item is accepted
// while a result waits; a stalled m_axis holds the sequencer in its final
// step until the register frees. Reset empties the store (count zero, memory
// contents left as they are) and sets both dimensions to 1024.
module sorted_sparse_matrix_store_unit #(
  parameter int unsigned CAPACITY   = 256,
  parameter int unsigned INDEX_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [ssms_pkg::REG_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row[9:0], column[19:10], write_value[51:20], zero fill [55:52]
  input  logic [ssms_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // read_value[31:0], status[33:32], zero fill [39:34]
  output logic [ssms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  import ssms_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = 2 * INDEX_BITS;
  localparam int unsigned EW = KW + VALUE_W;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_e state_q, state_d;

  logic [REG_W-1:0]    row_count_q, column_count_q;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic                cmd_q, cmd_d;
  logic [KW-1:0]       key_q, key_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [VALUE_W-1:0]  res_q, res_d;
  logic [STATUS_W-1:0] stat_q, stat_d;
  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  out_res_q, out_res_d;
  logic [STATUS_W-1:0] out_stat_q, out_stat_d;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [EW-1:0]       mem_wdata, mem_rdata;
  logic [KW-1:0]       rkey;
  logic [VALUE_W-1:0]  rval;

  logic [IDX_IN_W-1:0] in_row, in_col;
  logic [VALUE_W-1:0]  in_val;
  logic                in_bad;
  logic [CW-1:0]       mid;
  logic [CW:0]         idx_p1, idx_p2, lo_p1;
  logic                found, key_less;
  logic                out_free;

  assign in_row = s_axis_tdata[IDX_IN_W-1:0];
  assign in_col = s_axis_tdata[2*IDX_IN_W-1:IDX_IN_W];
  assign in_val = s_axis_tdata[2*IDX_IN_W+VALUE_W-1:2*IDX_IN_W];

  assign in_bad = ({1'b0, in_row} >= row_count_q) || ({1'b0, in_col} >= column_count_q)
               || ((32'(in_row) >> INDEX_BITS) != 32'd0)
               || ((32'(in_col) >> INDEX_BITS) != 32'd0);

  assign rkey     = mem_rdata[EW-1:VALUE_W];
  assign rval     = mem_rdata[VALUE_W-1:0];
  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_p1   = {1'b0, idx_q} + 1'b1;
  assign idx_p2   = {1'b0, idx_q} + 2'd2;
  assign lo_p1    = {1'b0, lo_q} + 1'b1;
  // the key compare on the read record serves every search step; the hit test compares for equality
  assign key_less = rkey < key_q;
  assign found    = (lo_q < count_q) && (rkey == key_q);
  assign out_free = !out_valid_q || m_axis_tready;

  ssms_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    val_d       = val_q;
    res_d       = res_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser;
          key_d  = (KW'(in_row) << INDEX_BITS) | KW'(in_col);
          val_d  = in_val;
          res_d  = '0;
          stat_d = STATUS_OK;
          lo_d   = '0;
          hi_d   = count_q;
          if (in_bad) begin
            stat_d  = STATUS_RANGE;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_RD: begin
        state_d = (lo_q == hi_q) ? ST_LOOK_RD : ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (key_less) begin
          lo_d = mid + 1'b1;
        end else begin
          hi_d = mid;
        end
        state_d = ST_SRCH_RD;
      end
      ST_LOOK_RD: begin
        state_d = ST_LOOK_CMP;
      end
      ST_LOOK_CMP: begin
        res_d   = found ? rval : '0;
        state_d = ST_DONE;
        if (cmd_q == CMD_WRITE) begin
          if (found) begin
            if (val_q == '0) begin
              if (lo_p1 < {1'b0, count_q}) begin
                idx_d   = lo_q;
                state_d = ST_DN_MOVE;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
          end else if (val_q != '0) begin
            if (count_q >= CAP) begin
              stat_d = STATUS_FULL;
            end else if (lo_q == count_q) begin
              state_d = ST_UP_INS;
            end else begin
              idx_d   = count_q;
              state_d = ST_UP_MOVE;
            end
          end
        end
      end
      ST_DN_MOVE: begin
        idx_d = idx_p1[CW-1:0];
        if (idx_p2 >= {1'b0, count_q}) begin
          count_d = count_q - 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_UP_MOVE: begin
        idx_d = idx_q - 1'b1;
        if ((idx_q - 1'b1) == lo_q) begin
          state_d = ST_UP_INS;
        end
      end
      ST_UP_INS: begin
        count_d = count_q + 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_stat_d  = stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and memory control
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_q[AW-1:0];
    mem_wdata     = mem_rdata;
    mem_raddr     = mid[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_LOOK_RD: begin
        mem_raddr = lo_q[AW-1:0];
      end
      ST_LOOK_CMP: begin
        // prime the first move: the record above for a removal, the last for an insert
        mem_raddr = found ? lo_p1[AW-1:0] : (count_q[AW-1:0] - 1'b1);
        if (cmd_q == CMD_WRITE && found && val_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = lo_q[AW-1:0];
          mem_wdata = {key_q, val_q};
        end
      end
      ST_DN_MOVE: begin
        mem_we    = 1'b1;
        mem_raddr = idx_p2[AW-1:0];
      end
      ST_UP_MOVE: begin
        mem_we    = 1'b1;
        mem_raddr = idx_q[AW-1:0] - 2'd2;
      end
      ST_UP_INS: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q[AW-1:0];
        mem_wdata = {key_q, val_q};
      end
      default: begin
        mem_raddr = mid[AW-1:0];
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - VALUE_W - STATUS_W)'(0), out_stat_q, out_res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      row_count_q    <= DIM_RESET;
      column_count_q <= DIM_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROW_COUNT) begin
          row_count_q <= cfg_data_i;
        end else begin
          column_count_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    idx_q      <= idx_d;
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    val_q      <= val_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
  end

endmodule
